/* sv/rgmf_pkg.sv */
// ----------------------------------------------------------------------------
// rgmf_pkg
// Shared types and constants of the rate-gated median window filter.
// ----------------------------------------------------------------------------
package rgmf_pkg;

  // Number of entries in the sliding window.
  localparam int WINDOW = 5;

  localparam int DIST_W   = 16;
  localparam int TIME_W   = 48;
  localparam int CFG_W    = 32;
  localparam int MEDIAN_W = DIST_W + 1;
  localparam int COUNT_W  = 3;
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W   = $clog2(WINDOW + 1);
  localparam int INDEX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_STALE_TIMEOUT   = 2'd1;

  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RESET = 32'd1000000;
  localparam logic [CFG_W-1:0] STALE_TIMEOUT_RESET   = 32'd5000000;

  // Request kinds.
  localparam logic REQ_FRAME   = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Sort key: the top bit marks an empty slot, so empty slots sort last.
  typedef logic [DIST_W:0] sort_key_t;

  // Control broadcast to every cell of the sorting row.
  typedef struct packed {
    logic load;
    logic step;
    logic phase;
  } sort_ctrl_t;

endpackage

/* sv/rgmf_sort_cell.sv */
// ----------------------------------------------------------------------------
// rgmf_sort_cell
// One cell of the odd-even transposition sorting row.
// ----------------------------------------------------------------------------
module rgmf_sort_cell (
  input  logic                  clk,
  input  rgmf_pkg::sort_ctrl_t  ctrl,
  input  logic                  parity,
  input  logic                  has_left,
  input  logic                  has_right,
  input  rgmf_pkg::sort_key_t   load_key,
  input  rgmf_pkg::sort_key_t   left_key,
  input  rgmf_pkg::sort_key_t   right_key,
  output rgmf_pkg::sort_key_t   key
);

  logic                takes_min;
  logic                takes_max;
  rgmf_pkg::sort_key_t key_next;

  // In a given phase a cell is either the lower or the upper member of a
  // compare pair, or it sits out at the end of the row.
  always_comb begin
    takes_min = has_right && (parity == ctrl.phase);
    takes_max = has_left && (parity != ctrl.phase);
    key_next  = key;
    if (takes_min) begin
      key_next = (right_key < key) ? right_key : key;
    end else if (takes_max) begin
      key_next = (left_key > key) ? left_key : key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= load_key;
    end else if (ctrl.step) begin
      key <= key_next;
    end
  end

endmodule

/* sv/rgmf_sort_chain.sv */
// ----------------------------------------------------------------------------
// rgmf_sort_chain
// Row of sorting cells; each step compares neighbouring pairs.
// ----------------------------------------------------------------------------
module rgmf_sort_chain (
  input  logic                 clk,
  input  rgmf_pkg::sort_ctrl_t ctrl,
  input  rgmf_pkg::sort_key_t  load_keys [rgmf_pkg::WINDOW],
  output rgmf_pkg::sort_key_t  keys      [rgmf_pkg::WINDOW]
);

  for (genvar i = 0; i < rgmf_pkg::WINDOW; i++) begin : g_cell
    rgmf_pkg::sort_key_t left_key;
    rgmf_pkg::sort_key_t right_key;

    if (i > 0) begin : g_left
      assign left_key = keys[i-1];
    end else begin : g_no_left
      assign left_key = '0;
    end

    if (i < rgmf_pkg::WINDOW - 1) begin : g_right
      assign right_key = keys[i+1];
    end else begin : g_no_right
      assign right_key = '0;
    end

    rgmf_sort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .parity    (1'(i % 2)),
      .has_left  (1'(i > 0)),
      .has_right (1'(i < rgmf_pkg::WINDOW - 1)),
      .load_key  (load_keys[i]),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[i])
    );
  end

endmodule

/* sv/rate_gated_median_window_filter_top.sv */
// ----------------------------------------------------------------------------
// rate_gated_median_window_filter_top
// Rate-gated sliding median of distance frames, with timeout clearing.
// ----------------------------------------------------------------------------
// Requests enter on item_valid/item_stall carrying req_type, range_mm and
// time_us; results leave on result_valid/result_stall. A request is taken
// when valid is high and stall low, on either channel.
// A distance frame closer than sample_interval to the last accepted frame is
// dropped with no result, and the block goes from the decide state straight
// back to idle. An accepted frame is written into the ring, the filled
// entries are loaded into a row of five sorting cells and sorted in five
// odd-even transposition steps, and the median is registered in the emit
// state. A timeout check passes from the decide state to the emit state.
// The block takes no new request until it is back in the idle state.
// The output register decouples the sides: the next request may be taken
// while a result waits; when result_stall holds a result, the following
// result waits in the block and item_stall stays high.
// Reset (synchronous, rst high) empties the window, forgets all frame times,
// drops any pending result and restores the register defaults. The registers
// are written through cfg_write/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rate_gated_median_window_filter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              req_type,
  input  logic [rgmf_pkg::DIST_W-1:0]       range_mm,
  input  logic [rgmf_pkg::TIME_W-1:0]       time_us,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [rgmf_pkg::MEDIAN_W-1:0]     median_half_mm,
  output logic [rgmf_pkg::COUNT_W-1:0]      sample_count,
  output logic                              cleared,
  input  logic                              cfg_write,
  input  logic [rgmf_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [rgmf_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t state;

  logic [rgmf_pkg::CFG_W-1:0]  sample_interval;
  logic [rgmf_pkg::CFG_W-1:0]  stale_timeout;

  logic [rgmf_pkg::DIST_W-1:0] window_store [rgmf_pkg::WINDOW];
  logic [rgmf_pkg::FILL_W-1:0] fill_count;
  logic [rgmf_pkg::SLOT_W-1:0] write_slot;
  logic [rgmf_pkg::TIME_W-1:0] last_accept_time;
  logic                        accept_seen;
  logic [rgmf_pkg::TIME_W-1:0] last_frame_time;
  logic                        frame_seen;

  logic                        req_kind;
  logic [rgmf_pkg::DIST_W-1:0] req_dist;
  logic [rgmf_pkg::TIME_W-1:0] req_time;
  logic                        res_frame;
  logic                        res_cleared;
  logic [rgmf_pkg::STEP_W-1:0] step_count;

  logic [rgmf_pkg::TIME_W-1:0] accept_age;
  logic [rgmf_pkg::TIME_W-1:0] frame_age;
  logic                        gated;
  logic                        stale;
  logic [rgmf_pkg::FILL_W-1:0] fill_next;
  logic [rgmf_pkg::SLOT_W-1:0] slot_next;
  logic                        frame_take;

  rgmf_pkg::sort_ctrl_t        sort_ctrl;
  rgmf_pkg::sort_key_t         load_keys [rgmf_pkg::WINDOW];
  rgmf_pkg::sort_key_t         keys      [rgmf_pkg::WINDOW];

  logic [rgmf_pkg::SLOT_W-1:0]   mid_idx;
  logic [rgmf_pkg::SLOT_W-1:0]   low_idx;
  logic [rgmf_pkg::DIST_W-1:0]   mid_val;
  logic [rgmf_pkg::DIST_W-1:0]   low_val;
  logic [rgmf_pkg::MEDIAN_W-1:0] median;
  logic                          out_free;

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Time differences wrap with the free-running counter.
  always_comb begin
    accept_age = req_time - last_accept_time;
    frame_age  = req_time - last_frame_time;
    gated      = accept_seen &&
                 (accept_age < rgmf_pkg::TIME_W'(sample_interval));
    stale      = !frame_seen ||
                 (frame_age >= rgmf_pkg::TIME_W'(stale_timeout));
    fill_next  = (fill_count == rgmf_pkg::FILL_W'(rgmf_pkg::WINDOW)) ?
                 fill_count : fill_count + 1'b1;
    slot_next  = (write_slot == rgmf_pkg::SLOT_W'(rgmf_pkg::WINDOW - 1)) ?
                 '0 : write_slot + 1'b1;
    frame_take = (state == ST_DECIDE) && (req_kind == rgmf_pkg::REQ_FRAME) &&
                 !gated;
  end

  // The row is loaded from the ring with the new entry bypassed in.
  always_comb begin
    for (int i = 0; i < rgmf_pkg::WINDOW; i++) begin
      load_keys[i][rgmf_pkg::DIST_W-1:0] =
        (write_slot == rgmf_pkg::SLOT_W'(i)) ? req_dist : window_store[i];
      load_keys[i][rgmf_pkg::DIST_W] = (rgmf_pkg::FILL_W'(i) >= fill_next);
    end
    sort_ctrl.load  = frame_take;
    sort_ctrl.step  = (state == ST_SORT);
    sort_ctrl.phase = step_count[0];
  end

  rgmf_sort_chain u_chain (
    .clk       (clk),
    .ctrl      (sort_ctrl),
    .load_keys (load_keys),
    .keys      (keys)
  );

  // Odd count: twice the middle entry; even count: sum of the middle pair.
  always_comb begin
    mid_idx = rgmf_pkg::SLOT_W'(fill_count >> 1);
    low_idx = mid_idx - 1'b1;
    mid_val = keys[mid_idx][rgmf_pkg::DIST_W-1:0];
    low_val = keys[low_idx][rgmf_pkg::DIST_W-1:0];
    if (fill_count[0]) begin
      median = {mid_val, 1'b0};
    end else begin
      median = {1'b0, mid_val} + {1'b0, low_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      sample_interval  <= rgmf_pkg::SAMPLE_INTERVAL_RESET;
      stale_timeout    <= rgmf_pkg::STALE_TIMEOUT_RESET;
      for (int i = 0; i < rgmf_pkg::WINDOW; i++) begin
        window_store[i] <= '0;
      end
      fill_count       <= '0;
      write_slot       <= '0;
      last_accept_time <= '0;
      accept_seen      <= 1'b0;
      last_frame_time  <= '0;
      frame_seen       <= 1'b0;
      step_count       <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == rgmf_pkg::CFG_SAMPLE_INTERVAL) begin
          sample_interval <= cfg_data;
        end else if (cfg_index == rgmf_pkg::CFG_STALE_TIMEOUT) begin
          stale_timeout <= cfg_data;
        end
      end

      if ((state == ST_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            req_kind <= req_type;
            req_dist <= range_mm;
            req_time <= time_us;
            state    <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          step_count <= '0;
          if (req_kind == rgmf_pkg::REQ_FRAME) begin
            last_frame_time <= req_time;
            frame_seen      <= 1'b1;
            if (gated) begin
              state <= ST_IDLE;
            end else begin
              last_accept_time         <= req_time;
              accept_seen              <= 1'b1;
              window_store[write_slot] <= req_dist;
              write_slot               <= slot_next;
              fill_count               <= fill_next;
              res_frame                <= 1'b1;
              res_cleared              <= 1'b0;
              state                    <= ST_SORT;
            end
          end else begin
            // The ring contents need no wiping: only filled slots are read.
            if (stale) begin
              fill_count <= '0;
              write_slot <= '0;
            end
            res_frame   <= 1'b0;
            res_cleared <= stale;
            state       <= ST_EMIT;
          end
        end

        ST_SORT: begin
          step_count <= step_count + 1'b1;
          if (step_count == rgmf_pkg::STEP_W'(rgmf_pkg::WINDOW - 1)) begin
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            median_half_mm <= res_frame ? median : '0;
            sample_count   <= rgmf_pkg::COUNT_W'(fill_count);
            cleared        <= res_cleared;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* verif/rate_gated_median_window_filter_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_gated_median_window_filter_top_tb
// Self-checking bench for the rate-gated median window filter.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests covers the first frame, rate drops,
// the ring wrapping, the timeout boundary and time wrapping past 2^48. Random
// requests follow, in phases that differ in register settings and in how the
// sender idles and the receiver stalls. Every accepted request runs through a
// behavioural copy of the filter, and each result leaving the block is
// compared field by field with the oldest reading still owed.
// ----------------------------------------------------------------------------
module rate_gated_median_window_filter_top_tb;

  localparam int N_DIRECTED      = 20;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;

  // The port decodes two index bits; these two select no register.
  localparam logic [rgmf_pkg::INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [rgmf_pkg::INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [rgmf_pkg::TIME_W-1:0] TIME_TOP = {rgmf_pkg::TIME_W{1'b1}};
  localparam logic [rgmf_pkg::TIME_W-1:0] TIME_MID = 48'h5555_5555_5555;

  typedef struct packed {
    logic [rgmf_pkg::MEDIAN_W-1:0] median;
    logic [rgmf_pkg::COUNT_W-1:0]  count;
    logic                          cleared;
  } reading_t;

  typedef struct packed {
    logic                        kind;
    logic [rgmf_pkg::DIST_W-1:0] mm;
    logic [rgmf_pkg::TIME_W-1:0] at;
    logic                        has_want;
    reading_t                    want;
  } dir_row_t;

  localparam reading_t NO_READING = '0;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic                          req_type = rgmf_pkg::REQ_FRAME;
  logic [rgmf_pkg::DIST_W-1:0]   range_mm = '0;
  logic [rgmf_pkg::TIME_W-1:0]   time_us = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [rgmf_pkg::MEDIAN_W-1:0] median_half_mm;
  logic [rgmf_pkg::COUNT_W-1:0]  sample_count;
  logic                          cleared;
  logic                          cfg_write = 1'b0;
  logic [rgmf_pkg::INDEX_W-1:0]  cfg_index = rgmf_pkg::CFG_SAMPLE_INTERVAL;
  logic [rgmf_pkg::CFG_W-1:0]    cfg_data = '0;

  rate_gated_median_window_filter_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .req_type       (req_type),
    .range_mm       (range_mm),
    .time_us        (time_us),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .median_half_mm (median_half_mm),
    .sample_count   (sample_count),
    .cleared        (cleared),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural copy of the filter state and its registers.
  logic [rgmf_pkg::DIST_W-1:0] win_dist [rgmf_pkg::WINDOW] = '{default: '0};
  int                          win_fill = 0;
  int                          win_slot = 0;
  logic [rgmf_pkg::TIME_W-1:0] accepted_at = '0;
  logic                        accepted_any = 1'b0;
  logic [rgmf_pkg::TIME_W-1:0] frame_at = '0;
  logic                        frame_any = 1'b0;
  logic [rgmf_pkg::CFG_W-1:0]  gap_min = rgmf_pkg::SAMPLE_INTERVAL_RESET;
  logic [rgmf_pkg::CFG_W-1:0]  stale_limit = rgmf_pkg::STALE_TIMEOUT_RESET;

  reading_t    pending_readings [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [rgmf_pkg::TIME_W-1:0] clock_us = '0;
  dir_row_t    directed_rows [N_DIRECTED];

  function automatic logic [rgmf_pkg::MEDIAN_W-1:0] window_median();
    logic [rgmf_pkg::DIST_W-1:0] s [rgmf_pkg::WINDOW];
    logic [rgmf_pkg::DIST_W-1:0] v;
    int i;
    int j;
    for (i = 0; i < rgmf_pkg::WINDOW; i++) s[i] = win_dist[i];
    for (i = 1; i < win_fill; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (win_fill == 0) return '0;
    if (win_fill % 2 == 1) return {s[win_fill/2], 1'b0};
    return rgmf_pkg::MEDIAN_W'(s[win_fill/2-1]) + rgmf_pkg::MEDIAN_W'(s[win_fill/2]);
  endfunction

  task automatic apply_request(input logic kind, input logic [rgmf_pkg::DIST_W-1:0] mm,
                               input logic [rgmf_pkg::TIME_W-1:0] now, output logic gives,
                               output reading_t r);
    logic [rgmf_pkg::TIME_W-1:0] since;
    logic                        wipe;
    gives = 1'b1;
    r = NO_READING;
    if (kind == rgmf_pkg::REQ_FRAME) begin
      since = now - accepted_at;
      frame_at = now;
      frame_any = 1'b1;
      if (accepted_any && since < rgmf_pkg::TIME_W'(gap_min)) begin
        gives = 1'b0;
      end else begin
        accepted_at = now;
        accepted_any = 1'b1;
        win_dist[win_slot] = mm;
        win_slot = (win_slot == rgmf_pkg::WINDOW - 1) ? 0 : win_slot + 1;
        if (win_fill < rgmf_pkg::WINDOW) win_fill++;
        r.median = window_median();
        r.count = rgmf_pkg::COUNT_W'(win_fill);
      end
    end else begin
      since = now - frame_at;
      wipe = !frame_any || since >= rgmf_pkg::TIME_W'(stale_limit);
      if (wipe) begin
        win_dist = '{default: '0};
        win_fill = 0;
        win_slot = 0;
      end
      r.count = rgmf_pkg::COUNT_W'(win_fill);
      r.cleared = wipe;
    end
  endtask

  function void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Spacing of the next frame: mostly around the sample interval so the ring
  // keeps filling, with a share of frames that the rate gate must drop.
  function automatic logic [rgmf_pkg::TIME_W-1:0] frame_gap();
    logic [63:0] d;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) d = 64'(gap_min) + 64'($urandom_range(0, gap_min / 8 + 2));
    else if (pick <= 7) d = (gap_min == 0) ? 64'd0 : 64'($urandom_range(0, gap_min - 1));
    else if (pick == 8) d = (gap_min == 0) ? 64'd0 : 64'(gap_min) - 64'($urandom_range(0, 1));
    else d = 64'($urandom);
    return rgmf_pkg::TIME_W'(d);
  endfunction

  // Age of a timeout check, clustered on the stale boundary.
  function automatic logic [rgmf_pkg::TIME_W-1:0] check_gap();
    logic [63:0] d;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) d = (stale_limit == 0) ? 64'($urandom_range(0, 2))
                                          : 64'(stale_limit) - 1 + 64'($urandom_range(0, 2));
    else if (pick <= 6) d = 64'($urandom_range(0, stale_limit));
    else d = 64'(stale_limit) + 64'($urandom);
    return rgmf_pkg::TIME_W'(d);
  endfunction

  task automatic send_request(input logic kind, input logic [rgmf_pkg::DIST_W-1:0] mm,
                              input logic [rgmf_pkg::TIME_W-1:0] at, input logic use_want,
                              input reading_t want);
    logic     gives;
    reading_t got;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    req_type   <= kind;
    range_mm   <= mm;
    time_us    <= at;
    do @(posedge clk); while (item_stall);
    apply_request(kind, mm, at, gives, got);
    if (use_want) pending_readings.push_back(want);
    else if (gives) pending_readings.push_back(got);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rgmf_pkg::INDEX_W-1:0] idx,
                           input logic [rgmf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      rgmf_pkg::CFG_SAMPLE_INTERVAL: gap_min = data;
      rgmf_pkg::CFG_STALE_TIMEOUT:   stale_limit = data;
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ns: result with no request outstanding: median %0d count %0d cleared %0d",
                 $time, median_half_mm, sample_count, cleared);
        mismatch_count++;
      end else begin
        reading_t want;
        want = pending_readings.pop_front();
        check_field("median_half_mm", want.median, median_half_mm);
        check_field("sample_count", want.count, sample_count);
        check_field("cleared", want.cleared, cleared);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rate_gated_median_window_filter_top test failed");
      $finish;
    end
  end

  initial begin
    logic [rgmf_pkg::CFG_W-1:0]  new_gap;
    logic [rgmf_pkg::CFG_W-1:0]  new_stale;
    logic                        kind;
    logic [rgmf_pkg::DIST_W-1:0] mm;
    logic [rgmf_pkg::TIME_W-1:0] at;
    int unsigned                 pick;

    // Reset registers hold: sample interval 1000000, stale timeout 5000000.
    directed_rows = '{
      '{rgmf_pkg::REQ_TIMEOUT, 16'd0,     48'd0,       1'b1, '{17'd0,     3'd0, 1'b1}},
      '{rgmf_pkg::REQ_FRAME,   16'd0,     48'd0,       1'b1, '{17'd0,     3'd1, 1'b0}},
      '{rgmf_pkg::REQ_FRAME,   16'd65535, 48'd999999,  1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd65535, 48'd1000000, 1'b1, '{17'd65535, 3'd2, 1'b0}},
      '{rgmf_pkg::REQ_FRAME,   16'd100,   48'd2000000, 1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd65535, 48'd3000000, 1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd7,     48'd4000000, 1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd40000, 48'd5000000, 1'b0, NO_READING},
      '{rgmf_pkg::REQ_TIMEOUT, 16'd0,     48'd9999999, 1'b1, '{17'd0,     3'd5, 1'b0}},
      '{rgmf_pkg::REQ_TIMEOUT, 16'd0,     48'd10000000, 1'b1, '{17'd0,    3'd0, 1'b1}},
      '{rgmf_pkg::REQ_FRAME,   16'd1234,  48'd10000000, 1'b1, '{17'd2468, 3'd1, 1'b0}},
      '{rgmf_pkg::REQ_FRAME,   16'd500,   TIME_TOP,    1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd9,     48'd1000,    1'b0, NO_READING},
      '{rgmf_pkg::REQ_FRAME,   16'd9,     48'd999999,  1'b0, NO_READING},
      '{rgmf_pkg::REQ_TIMEOUT, 16'd65535, TIME_TOP,    1'b1, '{17'd0,     3'd0, 1'b1}},
      '{rgmf_pkg::REQ_FRAME,   16'd65535, 48'hAAAA_AAAA_AAAA, 1'b1,
        '{17'd131070, 3'd1, 1'b0}},
      '{rgmf_pkg::REQ_FRAME,   16'd0,     TIME_MID,    1'b0, NO_READING},
      '{rgmf_pkg::REQ_TIMEOUT, 16'd0,     TIME_MID,    1'b1, '{17'd0,     3'd2, 1'b0}},
      '{rgmf_pkg::REQ_FRAME,   16'd1,     TIME_MID + 48'd999999,  1'b0, NO_READING},
      // A dropped frame still refreshes the frame time, so this does not clear.
      '{rgmf_pkg::REQ_TIMEOUT, 16'd0,     TIME_MID + 48'd5999998, 1'b1,
        '{17'd0, 3'd2, 1'b0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].mm, directed_rows[i].at,
                   directed_rows[i].has_want, directed_rows[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      clock_us = rgmf_pkg::TIME_W'({$urandom, $urandom});
      case (phase)
        0: begin new_gap = 32'd1000; new_stale = 32'd5000; end
        1: begin new_gap = '0; new_stale = '1; end
        2: begin new_gap = '1; new_stale = '0; end
        3: begin new_gap = $urandom_range(1, 5000); new_stale = $urandom_range(1, 20000); end
        4: begin new_gap = '1; new_stale = '1; clock_us = 48'hFFFF_0000_0000; end
        5: begin new_gap = 32'd1; new_stale = 32'd1; end
        6: begin new_gap = $urandom; new_stale = $urandom; end
        default: begin
          new_gap = rgmf_pkg::SAMPLE_INTERVAL_RESET;
          new_stale = rgmf_pkg::STALE_TIMEOUT_RESET;
        end
      endcase
      write_reg(rgmf_pkg::CFG_SAMPLE_INTERVAL, new_gap);
      write_reg(rgmf_pkg::CFG_STALE_TIMEOUT, new_stale);
      // The spare indexes must leave both registers untouched.
      write_reg(CFG_SPARE_2, $urandom);
      write_reg(CFG_SPARE_3, (phase % 2 == 0) ? '1 : '0);
      @(negedge clk);
      cfg_write <= 1'b0;

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off new requests until every reading owed has come back.
        if (n == ITEMS_PER_PHASE / 2) drain();
        pick = $urandom_range(0, 99);
        if (pick < 10) mm = '0;
        else if (pick < 20) mm = '1;
        else mm = rgmf_pkg::DIST_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          kind = rgmf_pkg::REQ_FRAME;
          clock_us = clock_us + frame_gap();
          at = clock_us;
        end else if (pick < 90) begin
          kind = rgmf_pkg::REQ_TIMEOUT;
          at = clock_us + check_gap();
        end else begin
          kind = 1'($urandom_range(0, 1));
          clock_us = rgmf_pkg::TIME_W'({$urandom, $urandom});
          at = clock_us;
        end
        send_request(kind, mm, at, 1'b0, NO_READING);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("rate_gated_median_window_filter_top test passed");
    end else begin
      $display("rate_gated_median_window_filter_top test failed");
    end
    $finish;
  end

endmodule
